/* src/tks_pkg.sv */
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types, token codes and character class helpers for the token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

   // Kind of the token that is currently open
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_NUM   = 2'd1,
      KIND_IDENT = 2'd2,
      KIND_KEYW  = 2'd3
   } token_kind_type;

   localparam logic [7:0] CODE_NUM   = 8'h23;  // '#'
   localparam logic [7:0] CODE_IDENT = 8'h78;  // 'x'
   localparam logic [7:0] UNDERSCORE = 8'h5F;  // '_'
   localparam logic [7:0] MAX_LEN_RESET = 8'd31;

   // One input item as held in the input register
   typedef struct packed {
      logic [7:0] char_in;
      logic       input_done;
   } req_item_type;

   // One result item as held in the result register
   typedef struct packed {
      logic [7:0] lexeme_char;
      logic [7:0] token_code;
      logic       token_start;
      logic       end_seen;
   } rsp_item_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   // Space, tab, LF, VT, FF and CR
   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   // True if character c may extend an open token of the given kind
   function automatic logic continues(input token_kind_type kind, input logic [7:0] c);
      logic ok;
      ok = 1'b0;
      case (kind)
         KIND_NUM:   ok = is_digit(c);
         KIND_IDENT: ok = is_digit(c) || is_lower(c) || is_upper(c) || (c == UNDERSCORE);
         KIND_KEYW:  ok = is_upper(c);
         default:    ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

`default_nettype wire

/* src/tks_in_reg.sv */
// ----------------------------------------------------------------------------
// tks_in_reg
// Input register stage: captures one character per transfer and holds it
// until the scan stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_char_in,
   input  wire logic                  req_input_done,
   output logic                       item_valid,
   output tks_pkg::req_item_type      item,
   input  wire logic                  item_take
);
   import tks_pkg::*;

   logic         valid_ff;
   req_item_type item_ff;

   // Stall while a held item is not taken this cycle
   assign req_stall  = valid_ff && !item_take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   // Advance the valid flag when the register frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || item_take) begin
         valid_ff <= req_valid;
      end
   end

   // Capture the payload on each transfer
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.char_in    <= req_char_in;
         item_ff.input_done <= req_input_done;
      end
   end

endmodule

`default_nettype wire

/* src/tks_scan.sv */
// ----------------------------------------------------------------------------
// tks_scan
// Scan stage: classifies the held character, updates the open-token state
// and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            max_len,
   input  wire logic                  item_valid,
   input  wire tks_pkg::req_item_type item,
   output logic                       item_take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tks_pkg::rsp_item_type      rsp_item
);
   import tks_pkg::*;

   token_kind_type kind_ff, kind_in;
   logic [7:0]     len_ff, len_in;
   logic [7:0]     code_ff, code_in;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_ff, rsp_in;
   logic           has_result;
   logic           out_free;
   logic [7:0]     c;

   assign c         = item.char_in;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign item_take = item_valid && (!has_result || out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Classify the character and work out the next token state
   always_comb begin
      kind_in    = kind_ff;
      len_in     = len_ff;
      code_in    = code_ff;
      has_result = 1'b1;
      rsp_in     = '0;
      if (item.input_done) begin
         kind_in        = KIND_NONE;
         len_in         = '0;
         code_in        = '0;
         rsp_in.end_seen = 1'b1;
      end else if (is_space(c)) begin
         kind_in    = KIND_NONE;
         len_in     = '0;
         has_result = 1'b0;
      end else if ((kind_ff != KIND_NONE) && (len_ff < max_len) && continues(kind_ff, c)) begin
         len_in             = len_ff + 8'd1;
         rsp_in.lexeme_char = c;
         rsp_in.token_code  = code_ff;
      end else begin
         if (is_digit(c)) begin
            kind_in = KIND_NUM;
            code_in = CODE_NUM;
         end else if (is_lower(c)) begin
            kind_in = KIND_IDENT;
            code_in = CODE_IDENT;
         end else if (is_upper(c)) begin
            kind_in = KIND_KEYW;
            code_in = c;
         end else begin
            kind_in = KIND_NONE;
            code_in = c;
         end
         len_in             = 8'd1;
         rsp_in.lexeme_char = c;
         rsp_in.token_code  = code_in;
         rsp_in.token_start = 1'b1;
      end
   end

   // Hold token state, advance it when the item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_NONE;
         len_ff  <= '0;
         code_ff <= '0;
      end else if (item_take) begin
         kind_ff <= kind_in;
         len_ff  <= len_in;
         code_ff <= code_in;
      end
   end

   // Result register valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_take && has_result;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (item_take && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* src/token_scanner_core.sv */
// ----------------------------------------------------------------------------
// token_scanner_core
// Byte-stream lexical scanner: numbers, identifiers, keywords and single
// special characters, one character per clock while not stalled.
// ----------------------------------------------------------------------------
// The scanner takes one character per clock and gives one result for every
// non-whitespace character and for every end-of-input item; whitespace gives
// none. A character enters the input register on its transfer and the single
// scan stage between the two registers loads its result into the result
// register. Intake and throughput are one item per clock while req_stall is low.
// The limit register csr_max_token_len (reset 31) may be written at any time
// the scanner is idle; csr_ready is always high.
`default_nettype none

module token_scanner_core (
   input  wire logic       clock,
   input  wire logic       reset,
   // input channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_input_done,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_lexeme_char,
   output logic [7:0]      rsp_token_code,
   output logic            rsp_token_start,
   output logic            rsp_end_seen,
   // configuration channel
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_max_token_len
);
   import tks_pkg::*;

   logic [7:0]   max_len_reg_ff;
   logic         item_valid;
   logic         item_take;
   req_item_type item;
   rsp_item_type rsp_item;

   assign csr_ready = 1'b1;

   // Hold the token length limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_reg_ff <= MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_reg_ff <= csr_max_token_len;
      end
   end

   tks_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .req_input_done (req_input_done),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take)
   );

   tks_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .max_len    (max_len_reg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   // Unpack the result register onto the ports
   assign rsp_lexeme_char = rsp_item.lexeme_char;
   assign rsp_token_code  = rsp_item.token_code;
   assign rsp_token_start = rsp_item.token_start;
   assign rsp_end_seen    = rsp_item.end_seen;

endmodule

`default_nettype wire
